### hdl/salc_pkg.sv
`timescale 1ns / 1ps

package salc_pkg;

  localparam int CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int FUNC_W = 2;
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_STORE  = 2'd1,
    FUNC_MODIFY = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_idx_t;

  localparam int SET_BITS_W   = 3;
  localparam int BLOCK_BITS_W = 5;
  localparam int WAYS_W       = 4;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

endpackage

### hdl/salc_if.sv
`timescale 1ns / 1ps

interface salc_req_if #(
  parameter int ADDR_WIDTH = 48
);
  logic                              valid;
  logic                              ready;
  logic [salc_pkg::FUNC_W-1:0]       func;
  logic [ADDR_WIDTH-1:0]             address;

  modport source (output valid, output func, output address, input ready);
  modport sink   (input valid, input func, input address, output ready);
endinterface

interface salc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         was_hit;
  logic                         was_miss;
  logic                         was_eviction;
  logic [salc_pkg::CNT_W-1:0]   hit_total;
  logic [salc_pkg::CNT_W-1:0]   miss_total;
  logic [salc_pkg::CNT_W-1:0]   eviction_total;

  modport source (output valid, output was_hit, output was_miss, output was_eviction,
                  output hit_total, output miss_total, output eviction_total,
                  input ready);
  modport sink   (input valid, input was_hit, input was_miss, input was_eviction,
                  input hit_total, input miss_total, input eviction_total,
                  output ready);
endinterface

### hdl/salc_store.sv
`timescale 1ns / 1ps

module salc_store #(
  parameter int SET_W    = 6,
  parameter int NUM_SETS = 64,
  parameter int ROW_W    = 648
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [SET_W-1:0] rd_set,
  output logic [ROW_W-1:0] rd_row,
  input  logic             wr_en,
  input  logic [SET_W-1:0] wr_set,
  input  logic [ROW_W-1:0] wr_row
);

  logic [ROW_W-1:0]    mem [NUM_SETS];
  logic [NUM_SETS-1:0] row_vld_r;
  logic [ROW_W-1:0]    rd_data_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_set] <= wr_row;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_set];
    end
  end

  // a row never written reads as all lines invalid with zero stamps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_set] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_vld_r[rd_set];
      end
    end
  end

  assign rd_row = rd_vld_r ? rd_data_r : '0;

endmodule

### hdl/salc_ctrl.sv
`timescale 1ns / 1ps

module salc_ctrl #(
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 48,
  parameter int SET_W        = 6,
  parameter int WC_W         = 4,
  parameter int ROW_W        = 648
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [salc_pkg::SET_BITS_W-1:0]     sb_eff,
  input  logic [salc_pkg::BLOCK_BITS_W-1:0]   block_bits,
  input  logic [WC_W-1:0]                     ways_eff,
  salc_req_if.sink                            in_ch,
  salc_rsp_if.source                          out_ch,
  output logic                                rd_en,
  output logic [SET_W-1:0]                    rd_set,
  input  logic [ROW_W-1:0]                    rd_row,
  output logic                                wr_en,
  output logic [SET_W-1:0]                    wr_set,
  output logic [ROW_W-1:0]                    wr_row
);

  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W   = salc_pkg::CNT_W;
  localparam int SHIFT_W = 7;

  typedef struct packed {
    logic                  vld;
    logic [ADDR_WIDTH-1:0] tag;
    logic [CNT_W-1:0]      stamp;
  } line_t;
  typedef line_t [MAX_WAYS-1:0] row_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_STAMP,
    S_WRITE
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == salc_pkg::CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  state_t                state_r;
  salc_pkg::func_t       func_r;
  logic [SET_W-1:0]      set_r;
  logic [ADDR_WIDTH-1:0] tag_r;
  logic                  hit_r, miss_r, evict_r;
  logic [WAY_W-1:0]      way_r;
  logic [WAY_W-1:0]      scan_r;
  logic [CNT_W-1:0]      vstamp_r;
  logic [CNT_W-1:0]      stamp_r;
  logic [CNT_W-1:0]      hits_r, misses_r, evicts_r;
  logic                  out_valid_r;
  logic                  out_hit_r, out_miss_r, out_evict_r;
  logic [CNT_W-1:0]      out_hits_r, out_misses_r, out_evicts_r;

  row_t                  rd_lines;
  row_t                  wr_lines;
  logic                  accept;
  logic                  fire;
  logic [ADDR_WIDTH-1:0] addr_shifted;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      set_calc;
  logic [SHIFT_W-1:0]    tag_shift;
  logic [ADDR_WIDTH-1:0] tag_calc;
  logic                  hit_found, inv_found;
  logic [WAY_W-1:0]      hit_way, inv_way;
  logic                  scan_lower;
  logic                  scan_last;
  logic [CNT_W+1:0]      stamp_sum;

  assign accept = in_ch.valid && in_ch.ready;
  assign fire   = (state_r == S_WRITE) && (!out_valid_r || out_ch.ready);

  // set and tag of the incoming item
  assign addr_shifted = in_ch.address >> block_bits;
  assign set_mask     = ~({SET_W{1'b1}} << sb_eff);
  assign set_calc     = addr_shifted[SET_W-1:0] & set_mask;
  assign tag_shift    = SHIFT_W'(block_bits) + SHIFT_W'(sb_eff);
  assign tag_calc     = in_ch.address >> tag_shift;

  assign rd_en  = accept;
  assign rd_set = set_calc;

  assign rd_lines = rd_row;

  // lowest matching way and lowest free way among the ways in use
  always_comb begin
    hit_found = 1'b0;
    inv_found = 1'b0;
    hit_way   = '0;
    inv_way   = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < int'(ways_eff)) begin
        if (rd_lines[w].vld && (rd_lines[w].tag == tag_r)) begin
          hit_found = 1'b1;
          hit_way   = WAY_W'(w);
        end
        if (!rd_lines[w].vld) begin
          inv_found = 1'b1;
          inv_way   = WAY_W'(w);
        end
      end
    end
  end

  assign scan_lower = rd_lines[scan_r].stamp < vstamp_r;
  assign scan_last  = (WC_W'(scan_r) + WC_W'(1)) == ways_eff;
  assign stamp_sum  = (CNT_W+2)'(hits_r) + (CNT_W+2)'(misses_r) + (CNT_W+2)'(evicts_r);

  always_comb begin
    wr_lines = rd_lines;
    wr_lines[way_r].vld   = 1'b1;
    wr_lines[way_r].tag   = tag_r;
    wr_lines[way_r].stamp = stamp_r;
  end

  assign wr_en  = fire && (func_r != salc_pkg::FUNC_NOP);
  assign wr_set = set_r;
  assign wr_row = wr_lines;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r  <= salc_pkg::func_t'(in_ch.func);
            set_r   <= set_calc;
            tag_r   <= tag_calc;
            hit_r   <= 1'b0;
            miss_r  <= 1'b0;
            evict_r <= 1'b0;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (func_r == salc_pkg::FUNC_NOP) begin
            state_r <= S_WRITE;
          end else if (hit_found) begin
            hit_r   <= 1'b1;
            way_r   <= hit_way;
            hits_r  <= sat_inc(hits_r);
            state_r <= S_STAMP;
          end else begin
            miss_r   <= 1'b1;
            misses_r <= sat_inc(misses_r);
            if (inv_found) begin
              way_r   <= inv_way;
              state_r <= S_STAMP;
            end else if (ways_eff == WC_W'(1)) begin
              way_r    <= '0;
              evict_r  <= 1'b1;
              evicts_r <= sat_inc(evicts_r);
              state_r  <= S_STAMP;
            end else begin
              way_r    <= '0;
              vstamp_r <= rd_lines[0].stamp;
              scan_r   <= WAY_W'(1);
              state_r  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // serial search for the oldest stamp, strict compare keeps lowest way on ties
          if (scan_lower) begin
            way_r    <= scan_r;
            vstamp_r <= rd_lines[scan_r].stamp;
          end
          scan_r <= scan_r + WAY_W'(1);
          if (scan_last) begin
            evict_r  <= 1'b1;
            evicts_r <= sat_inc(evicts_r);
            state_r  <= S_STAMP;
          end
        end
        S_STAMP: begin
          stamp_r <= (stamp_sum[CNT_W+1:CNT_W] != 2'b00) ? salc_pkg::CNT_MAX
                                                         : stamp_sum[CNT_W-1:0];
          // extra hit of a modify lands after the stamp is taken
          if (func_r == salc_pkg::FUNC_MODIFY) begin
            hits_r <= sat_inc(hits_r);
          end
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (fire) begin
            out_valid_r  <= 1'b1;
            out_hit_r    <= hit_r;
            out_miss_r   <= miss_r;
            out_evict_r  <= evict_r;
            out_hits_r   <= hits_r;
            out_misses_r <= misses_r;
            out_evicts_r <= evicts_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.was_hit        = out_hit_r;
  assign out_ch.was_miss       = out_miss_r;
  assign out_ch.was_eviction   = out_evict_r;
  assign out_ch.hit_total      = out_hits_r;
  assign out_ch.miss_total     = out_misses_r;
  assign out_ch.eviction_total = out_evicts_r;

endmodule

### hdl/set_assoc_lru_cache_model.sv
`timescale 1ns / 1ps
// an item passes the eval, stamp and write states before its result is valid (the
// unused access kind skips stamp), plus a serial oldest-line scan on a full-set miss
// one item at a time: the read-modify-write of one set row in the line memory must
// finish first; the write waits while an earlier result is held on the output
// reset: totals cleared and every set marked empty at once, no clearing pass

module set_assoc_lru_cache_model #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  salc_req_if.sink                          in_ch,
  salc_rsp_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int WC_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS + 1) : 1;
  localparam int LINE_W   = 1 + ADDR_WIDTH + salc_pkg::CNT_W;
  localparam int ROW_W    = MAX_WAYS * LINE_W;

  logic [salc_pkg::SET_BITS_W-1:0]   set_bits_r;
  logic [salc_pkg::BLOCK_BITS_W-1:0] block_bits_r;
  logic [salc_pkg::WAYS_W-1:0]       ways_r;
  logic [salc_pkg::SET_BITS_W-1:0]   sb_eff;
  logic [WC_W-1:0]                   ways_eff;

  logic             rd_en, wr_en;
  logic [SET_W-1:0] rd_set, wr_set;
  logic [ROW_W-1:0] rd_row, wr_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= salc_pkg::SET_BITS_RST;
      block_bits_r <= salc_pkg::BLOCK_BITS_RST;
      ways_r       <= salc_pkg::WAYS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        salc_pkg::CFG_SET_BITS:   set_bits_r   <= cfg_wdata[salc_pkg::SET_BITS_W-1:0];
        salc_pkg::CFG_BLOCK_BITS: block_bits_r <= cfg_wdata[salc_pkg::BLOCK_BITS_W-1:0];
        salc_pkg::CFG_WAYS:       ways_r       <= cfg_wdata[salc_pkg::WAYS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp the set bits and the way count to what the store holds
  always_comb begin
    if (int'(set_bits_r) > MAX_SET_BITS) begin
      sb_eff = salc_pkg::SET_BITS_W'(MAX_SET_BITS);
    end else begin
      sb_eff = set_bits_r;
    end
    if (ways_r == '0) begin
      ways_eff = WC_W'(1);
    end else if (int'(ways_r) > MAX_WAYS) begin
      ways_eff = WC_W'(MAX_WAYS);
    end else begin
      ways_eff = WC_W'(ways_r);
    end
  end

  salc_store #(
    .SET_W    (SET_W),
    .NUM_SETS (NUM_SETS),
    .ROW_W    (ROW_W)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (rd_en),
    .rd_set (rd_set),
    .rd_row (rd_row),
    .wr_en  (wr_en),
    .wr_set (wr_set),
    .wr_row (wr_row)
  );

  salc_ctrl #(
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH),
    .SET_W        (SET_W),
    .WC_W         (WC_W),
    .ROW_W        (ROW_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .sb_eff     (sb_eff),
    .block_bits (block_bits_r),
    .ways_eff   (ways_eff),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .rd_en      (rd_en),
    .rd_set     (rd_set),
    .rd_row     (rd_row),
    .wr_en      (wr_en),
    .wr_set     (wr_set),
    .wr_row     (wr_row)
  );

  // an eviction is always a miss, and hit and miss never come together
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (!(out_ch.was_hit && out_ch.was_miss) &&
                      (!out_ch.was_eviction || out_ch.was_miss)))
    else $error("inconsistent result flags");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while busy");

  // a reported hit or miss has already been counted
  a_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((!out_ch.was_hit || (out_ch.hit_total != '0)) &&
                      (!out_ch.was_miss || (out_ch.miss_total != '0))))
    else $error("result flag without count");

  // no memory write while a read of a new item is issued
  a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("read and write in the same cycle");

endmodule

### tb/sv/set_assoc_lru_cache_model_chk.sv
`timescale 1ns / 1ps

module set_assoc_lru_cache_model_chk #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  salc_req_if                             req,
  salc_rsp_if                             rsp,
  input  logic                            cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              errors,
  output int                              outstanding
);

  localparam int NUM_LINES = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int CNT_W     = salc_pkg::CNT_W;

  typedef struct packed {
    logic             was_hit;
    logic             was_miss;
    logic             was_eviction;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } access_result_t;

  logic                              line_valid [NUM_LINES];
  logic [ADDR_WIDTH-1:0]             line_tag   [NUM_LINES];
  logic [CNT_W-1:0]                  line_stamp [NUM_LINES];
  logic [CNT_W-1:0]                  hit_cnt, miss_cnt, evict_cnt;
  logic [salc_pkg::SET_BITS_W-1:0]   cfg_set_bits;
  logic [salc_pkg::BLOCK_BITS_W-1:0] cfg_block_bits;
  logic [salc_pkg::WAYS_W-1:0]       cfg_ways;

  access_result_t pending_results [$];

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == salc_pkg::CNT_MAX) ? v : v + 1'b1;
  endfunction

  // age stamp: sum of the three totals, saturating
  function automatic logic [CNT_W-1:0] age_now();
    logic [CNT_W+1:0] sum;
    sum = {2'b00, hit_cnt} + {2'b00, miss_cnt} + {2'b00, evict_cnt};
    return (sum > {2'b00, salc_pkg::CNT_MAX}) ? salc_pkg::CNT_MAX : sum[CNT_W-1:0];
  endfunction

  function automatic access_result_t predict_access(logic [salc_pkg::FUNC_W-1:0] f,
                                                    logic [ADDR_WIDTH-1:0] addr);
    access_result_t        r;
    int                    sb, ways, shift, base, victim;
    logic [63:0]           set_idx;
    logic [ADDR_WIDTH-1:0] tag;
    logic [CNT_W-1:0]      oldest;
    bit                    found;
    r = '0;
    if (salc_pkg::func_t'(f) != salc_pkg::FUNC_NOP) begin
      sb = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
      ways = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways));
      shift = int'(cfg_block_bits) + sb;
      set_idx = (64'(addr) >> cfg_block_bits) & ((64'd1 << sb) - 64'd1);
      tag = (shift >= ADDR_WIDTH) ? '0 : (addr >> shift);
      base = int'(set_idx) * MAX_WAYS;
      found = 1'b0;
      for (int w = 0; w < ways; w++) begin
        if (line_valid[base+w] && line_tag[base+w] == tag) begin
          r.was_hit = 1'b1;
          hit_cnt = sat_inc(hit_cnt);
          line_stamp[base+w] = age_now();
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        r.was_miss = 1'b1;
        miss_cnt = sat_inc(miss_cnt);
        for (int w = 0; w < ways; w++) begin
          if (!line_valid[base+w]) begin
            line_valid[base+w] = 1'b1;
            line_tag[base+w] = tag;
            line_stamp[base+w] = age_now();
            found = 1'b1;
            break;
          end
        end
      end
      if (!found) begin
        // set full: oldest stamp goes, lowest way on ties
        victim = 0;
        oldest = line_stamp[base];
        for (int w = 1; w < ways; w++) begin
          if (line_stamp[base+w] < oldest) begin
            oldest = line_stamp[base+w];
            victim = w;
          end
        end
        r.was_eviction = 1'b1;
        evict_cnt = sat_inc(evict_cnt);
        line_tag[base+victim] = tag;
        line_stamp[base+victim] = age_now();
      end
      if (salc_pkg::func_t'(f) == salc_pkg::FUNC_MODIFY) hit_cnt = sat_inc(hit_cnt);
    end
    r.hit_total = hit_cnt;
    r.miss_total = miss_cnt;
    r.eviction_total = evict_cnt;
    return r;
  endfunction

  function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("%0t mismatch on %s: expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch_channels
    access_result_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        line_valid[i] = 1'b0;
        line_tag[i] = '0;
        line_stamp[i] = '0;
      end
      hit_cnt = '0;
      miss_cnt = '0;
      evict_cnt = '0;
      cfg_set_bits = salc_pkg::SET_BITS_RST;
      cfg_block_bits = salc_pkg::BLOCK_BITS_RST;
      cfg_ways = salc_pkg::WAYS_RST;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (salc_pkg::cfg_idx_t'(cfg_index))
          salc_pkg::CFG_SET_BITS:
            cfg_set_bits = cfg_wdata[salc_pkg::SET_BITS_W-1:0];
          salc_pkg::CFG_BLOCK_BITS:
            cfg_block_bits = cfg_wdata[salc_pkg::BLOCK_BITS_W-1:0];
          salc_pkg::CFG_WAYS:
            cfg_ways = cfg_wdata[salc_pkg::WAYS_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        pending_results.push_back(predict_access(req.func, req.address));
      if (rsp.valid && rsp.ready) begin
        got.was_hit = rsp.was_hit;
        got.was_miss = rsp.was_miss;
        got.was_eviction = rsp.was_eviction;
        got.hit_total = rsp.hit_total;
        got.miss_total = rsp.miss_total;
        got.eviction_total = rsp.eviction_total;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t result with no access pending", $time);
        end else begin
          want = pending_results.pop_front();
          check_field("was_hit", CNT_W'(want.was_hit), CNT_W'(got.was_hit));
          check_field("was_miss", CNT_W'(want.was_miss), CNT_W'(got.was_miss));
          check_field("was_eviction", CNT_W'(want.was_eviction), CNT_W'(got.was_eviction));
          check_field("hit_total", want.hit_total, got.hit_total);
          check_field("miss_total", want.miss_total, got.miss_total);
          check_field("eviction_total", want.eviction_total, got.eviction_total);
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

### tb/sv/set_assoc_lru_cache_model_tb.sv
`timescale 1ns / 1ps

module set_assoc_lru_cache_model_tb;

  localparam int ADDR_W      = 48;
  localparam int MAX_SET     = 6;
  localparam int MAX_W       = 8;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 130;
  localparam int CFG_DW      = salc_pkg::CFG_DATA_W;

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_we;
  logic [salc_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DW-1:0]                 cfg_wdata;
  int                                errors;
  int                                outstanding;
  int                                quiet_cycles = 0;
  bit                                calm = 1'b0;  // no idling on either side
  int                                cur_sb, cur_bb, cur_ways;
  logic [ADDR_W-1:0]                 tag_base;

  // settings per phase, extremes and out-of-range values included
  int phase_sb   [PHASES] = '{4, 0, 6, 7, 3, 2, 5, 1, 6};
  int phase_bb   [PHASES] = '{4, 0, 16, 31, 5, 8, 2, 0, 31};
  int phase_ways [PHASES] = '{1, 1, 8, 15, 0, 4, 3, 8, 2};

  salc_req_if #(.ADDR_WIDTH(ADDR_W)) req_ch ();
  salc_rsp_if rsp_ch ();

  set_assoc_lru_cache_model #(
    .MAX_SET_BITS(MAX_SET),
    .MAX_WAYS(MAX_W),
    .ADDR_WIDTH(ADDR_W)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(req_ch),
    .out_ch(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  set_assoc_lru_cache_model_chk #(
    .MAX_SET_BITS(MAX_SET),
    .MAX_WAYS(MAX_W),
    .ADDR_WIDTH(ADDR_W)
  ) i_chk (
    .clk(clk),
    .rst_n(rst_n),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .errors(errors),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst_n) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= calm || ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("set_assoc_lru_cache_model_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_access(salc_pkg::func_t f, logic [ADDR_W-1:0] a);
    while (!calm && $urandom_range(99) < 16) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= f;
    req_ch.address <= a;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // drop valid, wait for every result, then let the block go quiet
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic configure(int sb, int bb, int ways);
    cfg_we <= 1'b1;
    cfg_index <= salc_pkg::CFG_SET_BITS;
    cfg_wdata <= CFG_DW'(sb);
    @(negedge clk);
    cfg_index <= salc_pkg::CFG_BLOCK_BITS;
    cfg_wdata <= CFG_DW'(bb);
    @(negedge clk);
    cfg_index <= salc_pkg::CFG_WAYS;
    cfg_wdata <= CFG_DW'(ways);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_sb = sb;
    cur_bb = bb;
    cur_ways = ways;
  endtask

  // mostly a small pool of tags over a few sets so lines get reused and evicted
  function automatic logic [ADDR_W-1:0] pick_address();
    int          sb, nsets, set_idx, ways;
    logic [63:0] a, tag;
    sb = (cur_sb > MAX_SET) ? MAX_SET : cur_sb;
    ways = (cur_ways == 0) ? 1 : ((cur_ways > MAX_W) ? MAX_W : cur_ways);
    if ($urandom_range(99) < 12) return ADDR_W'({$urandom, $urandom});
    nsets = 1 << sb;
    if ($urandom_range(3) == 0) set_idx = $urandom_range(nsets - 1);
    else set_idx = $urandom_range((nsets < 3) ? nsets - 1 : 2);
    tag = 64'(tag_base) + 64'($urandom_range(ways + 1));
    a = {$urandom, $urandom} & ((64'd1 << cur_bb) - 64'd1);
    a = a | (64'(set_idx) << cur_bb);
    a = a | (tag << (cur_bb + sb));
    return a[ADDR_W-1:0];
  endfunction

  function automatic salc_pkg::func_t pick_func();
    if ($urandom_range(99) < 6) return salc_pkg::FUNC_NOP;
    return salc_pkg::func_t'($urandom_range(2));
  endfunction

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = salc_pkg::CFG_SET_BITS;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.func = salc_pkg::FUNC_LOAD;
    req_ch.address = '0;
    rsp_ch.ready = 1'b0;
    cur_sb = int'(salc_pkg::SET_BITS_RST);
    cur_bb = int'(salc_pkg::BLOCK_BITS_RST);
    cur_ways = int'(salc_pkg::WAYS_RST);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // one way per set after reset: fill, hit, modify, conflict evictions, nop
    send_access(salc_pkg::FUNC_LOAD, 48'h0);
    send_access(salc_pkg::FUNC_LOAD, 48'h0);
    send_access(salc_pkg::FUNC_STORE, 48'hF);
    send_access(salc_pkg::FUNC_MODIFY, 48'h0);
    send_access(salc_pkg::FUNC_LOAD, 48'h100);
    send_access(salc_pkg::FUNC_LOAD, 48'h0);
    send_access(salc_pkg::FUNC_NOP, 48'h0);
    send_access(salc_pkg::FUNC_NOP, 48'hFFFF_FFFF_FFFF);
    send_access(salc_pkg::FUNC_LOAD, 48'hFFFF_FFFF_FFFF);
    send_access(salc_pkg::FUNC_MODIFY, 48'hFFFF_FFFF_FFFF);
    send_access(salc_pkg::FUNC_STORE, 48'h8000_0000_00F0);
    send_access(salc_pkg::FUNC_MODIFY, 48'h10);
    send_access(salc_pkg::FUNC_STORE, 48'h10);
    send_access(salc_pkg::FUNC_LOAD, 48'h5555_5555_5555);
    send_access(salc_pkg::FUNC_LOAD, 48'hAAAA_AAAA_AAAA);
    send_access(salc_pkg::FUNC_MODIFY, 48'hAAAA_AAAA_AAAA);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      configure(phase_sb[p], phase_bb[p], phase_ways[p]);
      tag_base = ADDR_W'({$urandom, $urandom});
      calm = (p == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) send_access(pick_func(), pick_address());
    end
    settle();

    if (errors == 0) $display("set_assoc_lru_cache_model_tb: clean");
    else $display("set_assoc_lru_cache_model_tb: errors");
    $finish;
  end

endmodule
